// File: hdl/sha1_little_endian_hash_defines.svh
// Assertion macros shared by the SHA-1 little-endian hash checker.
// No dependencies; included by the checker file.
`ifndef SHA1_LITTLE_ENDIAN_HASH_DEFINES_SVH
`define SHA1_LITTLE_ENDIAN_HASH_DEFINES_SVH

// Same-cycle implication under reset
`define SHA1LE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sha1le assertion failed");

// Next-cycle implication under reset
`define SHA1LE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sha1le assertion failed");

`endif

// File: hdl/sha1le_pkg.sv
// Constants and helper functions for the SHA-1 little-endian hash.
// No dependencies; imported by the top level and its checker.
package sha1le_pkg;

	localparam int unsigned DIGEST_WORDS = 5;
	localparam int unsigned BLK_WORDS    = 16;
	localparam int unsigned ROUNDS       = 80;

	localparam logic [31:0] IV [DIGEST_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [31:0] PAD_BYTE = 32'h00000080;

	// Rotate left by a constant amount
	function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// Round constant by round number
	function automatic logic [31:0] round_k(input logic [6:0] rnd);
		logic [31:0] k;
		if (rnd < 7'd20)
			k = K0;
		else if (rnd < 7'd40)
			k = K1;
		else if (rnd < 7'd60)
			k = K2;
		else
			k = K3;
		return k;
	endfunction

	// Boolean function by round number
	function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (rnd < 7'd20)
			f = (b & c) | (~b & d);
		else if (rnd < 7'd40)
			f = b ^ c ^ d;
		else if (rnd < 7'd60)
			f = (b & c) | (b & d) | (c & d);
		else
			f = b ^ c ^ d;
		return f;
	endfunction

endpackage

// File: hdl/sha1_little_endian_hash.sv
// SHA-1 over little-endian packed words. A word that does not fill a block is written to the block memory.
// A word that completes a block starts a compression: one memory prefetch, 80 rounds at
// one per cycle from the block memory and the schedule window, one chaining add.
// Padding writes one word a cycle and may run two compressions; five digest items follow.
// Reset (arst_n low, asynchronous) loads the initial chaining value, clears the bit count,
// block position and output item count; the block memory is not cleared.
module sha1_little_endian_hash
	import sha1le_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_ready,
	input  logic [31:0] msg_word,
	input  logic [2:0]  byte_count,
	input  logic        last,
	output logic        digest_valid,
	input  logic        digest_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_FINAL = 3'd3;
	localparam logic [2:0] ST_PAD   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]  state_q;
	logic [31:0] chain_q [DIGEST_WORDS];
	logic [63:0] bit_total_q;
	logic [3:0]  pos_q;
	logic        pad_act_q;
	logic        extra_q;
	logic        lo_done_q;
	logic        done_q;
	logic [6:0]  rnd_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] sched_q [BLK_WORDS];
	logic [31:0] rd_data_q;
	logic [31:0] blk_mem [BLK_WORDS];
	logic [31:0] dig_q [DIGEST_WORDS];
	logic [2:0]  out_cnt_q;

	logic        msg_acc;
	logic        dig_acc;
	logic [2:0]  n_bytes;
	logic [31:0] last_word_val;
	logic [31:0] pad_word;
	logic        wr_en;
	logic [31:0] wr_data;
	logic [3:0]  rd_addr;
	logic [31:0] w_cur;
	logic [31:0] t_sum;

	assign msg_ready = (state_q == ST_IDLE);
	assign msg_acc   = msg_valid && msg_ready;
	assign dig_acc   = digest_valid && digest_ready;

	// Clamp byte count, then mask unused bytes and place the pad byte
	assign n_bytes = (byte_count > 3'd4) ? 3'd4 : byte_count;
	always_comb begin
		case (n_bytes)
			3'd0: last_word_val = PAD_BYTE;
			3'd1: last_word_val = {16'h0000, 8'h80, msg_word[7:0]};
			3'd2: last_word_val = {8'h00, 8'h80, msg_word[15:0]};
			3'd3: last_word_val = {8'h80, msg_word[23:0]};
			default: last_word_val = msg_word;
		endcase
	end

	// Padding stream: extra pad byte, zeros, then length low and high
	always_comb begin
		if (extra_q)
			pad_word = PAD_BYTE;
		else if (pos_q == 4'd14)
			pad_word = bit_total_q[31:0];
		else if (pos_q == 4'd15 && lo_done_q)
			pad_word = bit_total_q[63:32];
		else
			pad_word = '0;
	end

	// Block memory port selection
	always_comb begin
		wr_en   = 1'b0;
		wr_data = pad_word;
		if (msg_acc) begin
			wr_en   = 1'b1;
			wr_data = last ? last_word_val : msg_word;
		end else if (state_q == ST_PAD) begin
			wr_en = 1'b1;
		end
	end
	assign rd_addr = (state_q == ST_LOAD) ? 4'd0 : rnd_q[3:0] + 4'd1;

	// Block memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			blk_mem[pos_q] <= wr_data;
		rd_data_q <= blk_mem[rd_addr];
	end

	// Message schedule and round sum
	assign w_cur = (rnd_q < 7'd16) ? rd_data_q :
		rol32(sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0], 1);
	assign t_sum = rol32(a_q, 5) + round_f(rnd_q, b_q, c_q, d_q) + e_q + round_k(rnd_q) + w_cur;

	// Working variables and schedule window
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (state_q == ST_ROUND) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= rol32(b_q, 30);
			d_q <= c_q;
			e_q <= d_q;
			for (int j = 0; j < BLK_WORDS - 1; j++)
				sched_q[j] <= sched_q[j + 1];
			sched_q[BLK_WORDS - 1] <= w_cur;
		end
	end

	// Digest buffer, shifts towards entry 0 as items leave
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_cnt_q == 3'd0) begin
			for (int j = 0; j < DIGEST_WORDS; j++)
				dig_q[j] <= chain_q[j];
		end else if (dig_acc) begin
			for (int j = 0; j < DIGEST_WORDS - 1; j++)
				dig_q[j] <= dig_q[j + 1];
		end
	end

	assign digest_valid = (out_cnt_q != 3'd0);
	assign digest_word  = dig_q[0];
	assign word_index   = 3'(DIGEST_WORDS) - out_cnt_q;
	assign last_word    = (out_cnt_q == 3'd1);

	// Control sequencer, chaining value and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			for (int j = 0; j < DIGEST_WORDS; j++)
				chain_q[j] <= IV[j];
			bit_total_q <= '0;
			pos_q       <= '0;
			pad_act_q   <= 1'b0;
			extra_q     <= 1'b0;
			lo_done_q   <= 1'b0;
			done_q      <= 1'b0;
			rnd_q       <= '0;
			out_cnt_q   <= '0;
		end else begin
			if (dig_acc)
				out_cnt_q <= out_cnt_q - 3'd1;
			case (state_q)
				ST_IDLE: begin
					if (msg_acc) begin
						pos_q <= pos_q + 4'd1;
						if (last) begin
							bit_total_q <= bit_total_q + {58'd0, n_bytes, 3'd0};
							pad_act_q   <= 1'b1;
							extra_q     <= (n_bytes == 3'd4);
							lo_done_q   <= 1'b0;
							done_q      <= 1'b0;
							state_q     <= (pos_q == 4'd15) ? ST_LOAD : ST_PAD;
						end else begin
							bit_total_q <= bit_total_q + 64'd32;
							if (pos_q == 4'd15)
								state_q <= ST_LOAD;
						end
					end
				end
				ST_PAD: begin
					pos_q   <= pos_q + 4'd1;
					extra_q <= 1'b0;
					if (!extra_q && pos_q == 4'd14)
						lo_done_q <= 1'b1;
					if (pos_q == 4'd15) begin
						if (!extra_q && lo_done_q)
							done_q <= 1'b1;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					rnd_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'(ROUNDS - 1))
						state_q <= ST_FINAL;
				end
				ST_FINAL: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q;
					if (done_q)
						state_q <= ST_OUT;
					else if (pad_act_q)
						state_q <= ST_PAD;
					else
						state_q <= ST_IDLE;
				end
				ST_OUT: begin
					// wait for the previous digest to drain, then reinitialise
					if (out_cnt_q == 3'd0) begin
						out_cnt_q   <= 3'(DIGEST_WORDS);
						for (int j = 0; j < DIGEST_WORDS; j++)
							chain_q[j] <= IV[j];
						bit_total_q <= '0;
						pos_q       <= '0;
						pad_act_q   <= 1'b0;
						done_q      <= 1'b0;
						lo_done_q   <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/sha1le_checker.sv
// Port-level checker for the SHA-1 little-endian hash, bound to the top level.
// Depends on sha1le_pkg and sha1_little_endian_hash_defines.svh.
`include "sha1_little_endian_hash_defines.svh"

module sha1le_checker
	import sha1le_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        msg_valid,
	input logic        msg_ready,
	input logic [31:0] msg_word,
	input logic [2:0]  byte_count,
	input logic        last,
	input logic        digest_valid,
	input logic        digest_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);

	// A stalled digest item holds
	`SHA1LE_ASSERT_NXT(a_dig_hold, clk, arst_n, digest_valid && !digest_ready, digest_valid && $stable(digest_word) && $stable(word_index))

	// Digest items follow in index order with no gap
	`SHA1LE_ASSERT_NXT(a_dig_seq, clk, arst_n, digest_valid && digest_ready && !last_word, digest_valid && (word_index == $past(word_index) + 3'd1))

	// The final flag marks exactly the fifth digest item
	`SHA1LE_ASSERT_IMP(a_dig_last, clk, arst_n, digest_valid, last_word == (word_index == 3'(DIGEST_WORDS - 1)))

	// A final message item starts padding or a compression, so input stalls next cycle
	`SHA1LE_ASSERT_NXT(a_last_stall, clk, arst_n, msg_valid && msg_ready && last, !msg_ready)

endmodule

bind sha1_little_endian_hash sha1le_checker u_sha1le_checker (.*);

// File: tb/sv/sha1_little_endian_hash_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for sha1_little_endian_hash: directed and random messages against a SHA-1 predictor.
// Depends only on the top level; no files or arguments are read.

module sha1_little_endian_hash_test;

	localparam int unsigned DIGEST_COUNT = 5;
	localparam int unsigned LAST_INDEX   = 4;

	// Digest predictor and store of expected digest items
	class digest_tracker;
		typedef struct packed {
			bit [31:0] word;
			bit [2:0]  index;
			bit        fin;
		} digest_t;

		bit [31:0] chain_init [DIGEST_COUNT] = '{
			32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
		};
		bit [31:0] round_const [4] = '{
			32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
		};

		bit [31:0] chain [DIGEST_COUNT];
		bit [31:0] blk [16];
		bit [63:0] bit_len;
		bit [3:0]  slot;
		digest_t   digest_q [$];
		int        mismatches;

		function new();
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			for (int i = 0; i < DIGEST_COUNT; i++)
				chain[i] = chain_init[i];
			bit_len = '0;
			slot = '0;
		endfunction

		function bit [31:0] rot_left(bit [31:0] x, int unsigned n);
			return (x << n) | (x >> (32 - n));
		endfunction

		// 80 rounds over the buffered block, then the chaining add
		function void hash_block();
			bit [31:0] sched [80];
			bit [31:0] a, b, c, d, e, f, k, t;
			for (int r = 0; r < 16; r++)
				sched[r] = blk[r];
			for (int r = 16; r < 80; r++)
				sched[r] = rot_left(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			e = chain[4];
			for (int r = 0; r < 80; r++) begin
				if (r < 20) begin
					f = (b & c) | (~b & d);
					k = round_const[0];
				end else if (r < 40) begin
					f = b ^ c ^ d;
					k = round_const[1];
				end else if (r < 60) begin
					f = (b & c) | (b & d) | (c & d);
					k = round_const[2];
				end else begin
					f = b ^ c ^ d;
					k = round_const[3];
				end
				t = rot_left(a, 5) + f + e + k + sched[r];
				e = d;
				d = c;
				c = rot_left(b, 30);
				b = a;
				a = t;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
			chain[4] += e;
		endfunction

		function void load_word(bit [31:0] w);
			blk[slot] = w;
			slot++;
			if (slot == 0)
				hash_block();
		endfunction

		// Accepted input item: buffer it, and on the final word pad and predict the digest
		function void note_item(bit [31:0] w, bit [2:0] cnt, bit fin);
			bit [2:0]  n;
			bit [31:0] mask;
			n = (cnt > 3'd4) ? 3'd4 : cnt;
			if (!fin) begin
				// non-final words always count as four bytes
				load_word(w);
				bit_len += 64'd32;
				return;
			end
			bit_len += 64'(8 * n);
			if (n < 3'd4) begin
				mask = (n == 0) ? 32'd0 : ((32'd1 << (8 * n)) - 32'd1);
				load_word((w & mask) | (32'h80 << (8 * n)));
			end else begin
				load_word(w);
				load_word(32'h80);
			end
			while (slot != 4'd14)
				load_word(32'd0);
			load_word(bit_len[31:0]);
			load_word(bit_len[63:32]);
			for (int i = 0; i < DIGEST_COUNT; i++)
				digest_q.push_back('{chain[i], 3'(i), i == LAST_INDEX});
			restart();
		endfunction

		task report(string what);
			$display("%0t ns  mismatch: %s", $time, what);
			mismatches++;
		endtask

		// Accepted digest item against the oldest prediction
		task check_result(bit [31:0] word, bit [2:0] index, bit fin);
			digest_t want;
			if (digest_q.size() == 0) begin
				report($sformatf("digest item %h/%0d with nothing predicted", word, index));
				return;
			end
			want = digest_q.pop_front();
			if (word !== want.word)
				report($sformatf("digest_word %h, predicted %h", word, want.word));
			if (index !== want.index)
				report($sformatf("word_index %0d, predicted %0d", index, want.index));
			if (fin !== want.fin)
				report($sformatf("last_word %b, predicted %b", fin, want.fin));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        msg_valid = 1'b0;
	logic        msg_ready;
	logic [31:0] msg_word = '0;
	logic [2:0]  byte_count = '0;
	logic        last = 1'b0;
	logic        digest_valid;
	logic        digest_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	digest_tracker tracker = new();

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	int items_sent = 0;

	sha1_little_endian_hash DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_ready    (msg_ready),
		.msg_word     (msg_word),
		.byte_count   (byte_count),
		.last         (last),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.last_word    (last_word)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: random stalls, plus a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			digest_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			digest_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Digest items are checked as they are accepted
	always @(posedge clk) begin
		if (arst_n && digest_valid && digest_ready)
			tracker.check_result(digest_word, word_index, last_word);
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(input logic [31:0] w, input logic [2:0] cnt, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			msg_valid <= 1'b0;
			@(negedge clk);
		end
		msg_valid  <= 1'b1;
		msg_word   <= w;
		byte_count <= cnt;
		last       <= fin;
		@(posedge clk);
		while (!msg_ready)
			@(posedge clk);
		tracker.note_item(w, cnt, fin);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_random_message(input int len);
		logic [31:0] w;
		logic [2:0]  cnt;
		int          pick;
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(19);
			w = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFFFFFF : $urandom;
			if (i == len - 1)
				cnt = 3'($urandom_range(7));
			else
				cnt = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'd4;
			send_item(w, cnt, i == len - 1);
		end
	endtask

	task automatic wait_drained();
		while (tracker.digest_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int target;
		int pick;
		int len;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed messages
		send_idle_pct = 20;
		recv_idle_pct = 64;
		send_item(32'h00000000, 3'd0, 1'b1);      // empty message
		send_item(32'hFFFFFFFF, 3'd4, 1'b1);      // one full word, pad in next slot
		send_item(32'hA5C3_0F12, 3'd7, 1'b1);     // count above four
		send_item(32'h12345678, 3'd1, 1'b0);      // short non-final word counts as full
		send_item(32'hFFFFFFFF, 3'd2, 1'b1);      // upper bytes must be cleared
		send_item(32'hFFFFFFFF, 3'd3, 1'b1);
		send_item(32'h8badf00d, 3'd5, 1'b1);
		send_item(32'h0BADCAFE, 3'd6, 1'b1);
		// final full word in slot 13: pad spills into a second block
		for (int i = 0; i < 13; i++)
			send_item(32'd0, 3'd4, 1'b0);
		send_item(32'hFFFFFFFF, 3'd4, 1'b1);
		msg_valid <= 1'b0;
		wait_drained();

		// Random messages in three idling regimes
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 20;
					recv_idle_pct = 64;
				end
				1: begin
					send_idle_pct = 64;
					recv_idle_pct = 20;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_left = 600;      // long stall so the block backs up
				end
			endcase
			target = items_sent + 170;
			while (items_sent < target) begin
				pick = $urandom_range(19);
				if (pick < 14)
					len = $urandom_range(1, 20);
				else if (pick < 19)
					len = $urandom_range(21, 40);
				else
					len = $urandom_range(41, 70);
				send_random_message(len);
			end
			msg_valid <= 1'b0;
			wait_drained();
		end

		// Quiet tail to catch stray digest items
		repeat (400) @(negedge clk);
		if (tracker.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: sha1_little_endian_hash.f
+incdir+hdl
hdl/sha1le_pkg.sv
hdl/sha1_little_endian_hash.sv
hdl/sha1le_checker.sv
tb/sv/sha1_little_endian_hash_test.sv
